>>> hw/rtl/icf_pkg.sv
// icf_pkg: shared types and constants for the instruction cache fill core
// used by icf_ctrl, icf_dp and direct_mapped_icache_fill_core; no dependencies

package icf_pkg;

  localparam int ADDR_W          = 32;
  localparam int DATA_W          = 32;
  localparam int SET_BITS        = 9;
  localparam int LINE_LOG2       = 5;
  localparam int NUM_SETS        = 1 << SET_BITS;
  localparam int WORD_IDX_W      = SET_BITS + LINE_LOG2 - 2;
  localparam int NUM_WORDS       = 1 << WORD_IDX_W;
  localparam int WORDS_PER_LINE  = 1 << (LINE_LOG2 - 2);
  localparam int TAG_W           = ADDR_W - SET_BITS - LINE_LOG2;
  localparam int TAG_ENTRY_W     = TAG_W + 1;
  localparam int WL_W            = $clog2(WORDS_PER_LINE) + 1;
  localparam int LAT_W           = 4;
  localparam int WORD_BYTES      = 4;

  localparam logic [LAT_W-1:0] MEM_LATENCY_RST = LAT_W'(6);

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] mem_word;
  } in_t;

  typedef struct packed {
    logic              ready_res;
    logic [DATA_W-1:0] read_data;
    logic              read_valid;
    logic [ADDR_W-1:0] fill_addr;
  } out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef enum logic [1:0] {
    M_READY,
    M_WANT,
    M_FILL,
    M_UPDATE
  } mode_t;

  typedef struct packed {
    logic capture;
    logic rd_miss;
    logic clr_write;
    logic miss_load;
    logic wait_load;
    logic wait_dec;
    logic fill_write;
    logic tag_write;
    logic res_load;
    logic rvalid;
    logic ready_res;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic wait_zero;
    logic left_zero;
    logic left_one;
    logic clear_done;
  } stat_t;

endpackage

>>> hw/rtl/direct_mapped_icache_fill_core.sv
// direct_mapped_icache_fill_core: top level of the direct-mapped read cache with line fill
// depends on icf_pkg, icf_ctrl, icf_dp (and icf_ram through icf_dp)
// timing: the accepting edge reads the tag and data rams into their output registers; the execute
// state then registers the result and raises done
// a new word is accepted only after the previous one leaves the execute state (busy is high there)
// reset: after rst a tag clearing pass over all NUM_SETS (512) sets runs with busy high;
// results carry no backpressure: each sits on result for one cycle under done

module direct_mapped_icache_fill_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  icf_pkg::in_t               req,
  output logic                       done,
  output icf_pkg::out_t              result,
  input  logic                       cfg_we,
  input  logic [icf_pkg::LAT_W-1:0]  cfg_data
);

  icf_pkg::cmd_t  cmd;
  icf_pkg::stat_t stat;

  icf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  icf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result)
  );

endmodule

>>> hw/rtl/icf_ram.sv
// icf_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies

module icf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/icf_ctrl.sv
// icf_ctrl: sequencer for the cache fill core, tracks the cache mode and the step phase
// depends on icf_pkg

module icf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  input  icf_pkg::stat_t stat,
  output icf_pkg::cmd_t  cmd
);

  icf_pkg::state_t state;
  icf_pkg::state_t state_next;
  icf_pkg::mode_t  mode;
  icf_pkg::mode_t  mode_next;
  logic            done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= icf_pkg::ST_CLEAR;
      mode  <= icf_pkg::M_READY;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    mode_next  = mode;
    done_next  = 1'b0;
    cmd        = '0;
    case (state)
      icf_pkg::ST_CLEAR: begin
        // wipe the tag store one set per cycle
        cmd.clr_write = 1'b1;
        if (stat.clear_done) begin
          state_next = icf_pkg::ST_IDLE;
        end
      end
      icf_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          cmd.rd_miss = (mode == icf_pkg::M_UPDATE);
          state_next  = icf_pkg::ST_EXEC;
        end
      end
      icf_pkg::ST_EXEC: begin
        state_next   = icf_pkg::ST_IDLE;
        done_next    = 1'b1;
        cmd.res_load = 1'b1;
        case (mode)
          icf_pkg::M_READY: begin
            if (stat.hit) begin
              cmd.rvalid = 1'b1;
            end else begin
              cmd.miss_load = 1'b1;
              mode_next     = icf_pkg::M_WANT;
            end
          end
          icf_pkg::M_WANT: begin
            cmd.wait_load = 1'b1;
            mode_next     = icf_pkg::M_FILL;
          end
          icf_pkg::M_FILL: begin
            if (stat.wait_zero) begin
              if (!stat.left_zero) begin
                cmd.fill_write = 1'b1;
                if (stat.left_one) begin
                  mode_next = icf_pkg::M_UPDATE;
                end
              end
            end else begin
              cmd.wait_dec = 1'b1;
            end
          end
          icf_pkg::M_UPDATE: begin
            cmd.tag_write = 1'b1;
            cmd.rvalid    = 1'b1;
            mode_next     = icf_pkg::M_READY;
          end
          default: begin
            mode_next = icf_pkg::M_READY;
          end
        endcase
      end
      default: begin
        state_next = icf_pkg::ST_IDLE;
      end
    endcase
    cmd.ready_res = (mode_next == icf_pkg::M_READY);
  end

  assign busy = (state != icf_pkg::ST_IDLE);

`ifndef SYNTH
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == icf_pkg::ST_EXEC))
    else $error("accepted word did not enter execute");
  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    (state == icf_pkg::ST_EXEC) |=> done)
    else $error("execute cycle gave no result");
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == icf_pkg::ST_CLEAR) |-> (!cmd.capture && !cmd.fill_write && !cmd.tag_write))
    else $error("activity during tag clearing");
`endif

endmodule

>>> hw/rtl/icf_dp.sv
// icf_dp: datapath of the cache fill core: tag and data stores, fill counters, result register
// depends on icf_pkg and icf_ram

module icf_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  icf_pkg::in_t               req,
  input  logic                       cfg_we,
  input  logic [icf_pkg::LAT_W-1:0]  cfg_data,
  input  icf_pkg::cmd_t              cmd,
  output icf_pkg::stat_t             stat,
  output icf_pkg::out_t              result
);

  localparam int AW  = icf_pkg::ADDR_W;
  localparam int LL  = icf_pkg::LINE_LOG2;
  localparam int SB  = icf_pkg::SET_BITS;
  localparam int TW  = icf_pkg::TAG_W;
  localparam int WIW = icf_pkg::WORD_IDX_W;

  logic [AW-1:0]                    addr_q;
  logic [icf_pkg::DATA_W-1:0]       mword_q;
  logic [icf_pkg::LAT_W-1:0]        mem_latency;
  logic [icf_pkg::WL_W-1:0]         words_left;
  logic [AW-1:0]                    fill_pointer;
  logic [AW-1:0]                    fill_pointer_next;
  logic [TW-1:0]                    miss_tag;
  logic [SB-1:0]                    miss_set;
  logic [WIW-1:0]                   miss_word_index;
  logic [icf_pkg::LAT_W-1:0]        wait_count;
  logic [SB-1:0]                    clr_cnt;

  logic                             tag_we;
  logic [SB-1:0]                    tag_waddr;
  logic [icf_pkg::TAG_ENTRY_W-1:0]  tag_wdata;
  logic [icf_pkg::TAG_ENTRY_W-1:0]  tag_q;
  logic [WIW-1:0]                   data_raddr;
  logic [icf_pkg::DATA_W-1:0]       data_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q  <= req.address;
      mword_q <= req.mem_word;
    end
    if (cmd.res_load) begin
      result.ready_res  <= cmd.ready_res;
      result.read_data  <= cmd.rvalid ? data_q : '0;
      result.read_valid <= cmd.rvalid;
      result.fill_addr  <= fill_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_latency     <= icf_pkg::MEM_LATENCY_RST;
      words_left      <= '0;
      fill_pointer    <= '0;
      miss_tag        <= '0;
      miss_set        <= '0;
      miss_word_index <= '0;
      wait_count      <= '0;
      clr_cnt         <= '0;
    end else begin
      if (cfg_we) begin
        mem_latency <= cfg_data;
      end
      if (cmd.clr_write) begin
        clr_cnt <= clr_cnt + SB'(1);
      end
      if (cmd.miss_load) begin
        words_left      <= icf_pkg::WL_W'(icf_pkg::WORDS_PER_LINE);
        miss_tag        <= addr_q[AW-1 -: TW];
        miss_set        <= addr_q[LL +: SB];
        miss_word_index <= addr_q[2 +: WIW];
      end
      if (cmd.fill_write) begin
        words_left <= words_left - icf_pkg::WL_W'(1);
      end
      if (cmd.wait_load) begin
        wait_count <= mem_latency;
      end else if (cmd.wait_dec) begin
        wait_count <= wait_count - icf_pkg::LAT_W'(1);
      end
      fill_pointer <= fill_pointer_next;
    end
  end

  always_comb begin
    fill_pointer_next = fill_pointer;
    if (cmd.miss_load) begin
      // line base of the missed address
      fill_pointer_next = {addr_q[AW-1:LL], {LL{1'b0}}};
    end else if (cmd.fill_write) begin
      fill_pointer_next = fill_pointer + AW'(icf_pkg::WORD_BYTES);
    end
  end

  assign tag_we    = cmd.clr_write | cmd.tag_write;
  assign tag_waddr = cmd.clr_write ? clr_cnt : miss_set;
  assign tag_wdata = cmd.clr_write ? '0 : {1'b1, miss_tag};

  icf_ram #(
    .WIDTH (icf_pkg::TAG_ENTRY_W),
    .DEPTH (icf_pkg::NUM_SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (cmd.capture),
    .raddr (req.address[LL +: SB]),
    .rdata (tag_q)
  );

  // the tag update step returns the word that missed
  assign data_raddr = cmd.rd_miss ? miss_word_index : req.address[2 +: WIW];

  icf_ram #(
    .WIDTH (icf_pkg::DATA_W),
    .DEPTH (icf_pkg::NUM_WORDS)
  ) u_data_ram (
    .clk   (clk),
    .we    (cmd.fill_write),
    .waddr (fill_pointer[2 +: WIW]),
    .wdata (mword_q),
    .re    (cmd.capture),
    .raddr (data_raddr),
    .rdata (data_q)
  );

  assign stat.hit        = tag_q[TW] && (tag_q[TW-1:0] == addr_q[AW-1 -: TW]);
  assign stat.wait_zero  = (wait_count == '0);
  assign stat.left_zero  = (words_left == '0);
  assign stat.left_one   = (words_left == icf_pkg::WL_W'(1));
  assign stat.clear_done = &clr_cnt;

endmodule

>>> tb/tb_direct_mapped_icache_fill_core.sv
// tb_direct_mapped_icache_fill_core: self-checking bench for the direct-mapped read cache
// a directed table, partly with fixed expected results, then random address streams under several
// fill latencies checked against an in-bench cache predictor; depends on icf_pkg and direct_mapped_icache_fill_core

module tb_direct_mapped_icache_fill_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    icf_pkg::in_t  req;
    bit            typed;
    icf_pkg::out_t want;
  } stim_row_t;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  icf_pkg::in_t                        req = '0;
  logic                                done;
  icf_pkg::out_t                       result;
  logic                                cfg_we = 1'b0;
  logic [icf_pkg::LAT_W-1:0]           cfg_data = '0;

  // predictor copy of the cache
  icf_pkg::mode_t                      cache_mode = icf_pkg::M_READY;
  logic [icf_pkg::LAT_W-1:0]           mem_latency = icf_pkg::MEM_LATENCY_RST;
  logic [icf_pkg::TAG_W-1:0]           tag_mem [icf_pkg::NUM_SETS];
  bit                                  tag_ok [icf_pkg::NUM_SETS];
  logic [icf_pkg::DATA_W-1:0]          line_mem [icf_pkg::NUM_WORDS];
  logic [icf_pkg::WL_W-1:0]            words_left = '0;
  logic [icf_pkg::ADDR_W-1:0]          fill_ptr = '0;
  logic [icf_pkg::TAG_W-1:0]           miss_tag = '0;
  logic [icf_pkg::SET_BITS-1:0]        miss_set = '0;
  logic [icf_pkg::WORD_IDX_W-1:0]      miss_widx = '0;
  logic [icf_pkg::LAT_W-1:0]           wait_left = '0;

  icf_pkg::out_t                       expected_words [$];
  int                                  mismatches = 0;
  stim_row_t                           plan [$];
  logic [icf_pkg::TAG_W-1:0]           tag_pool [4];
  logic [icf_pkg::SET_BITS-1:0]        set_pool [8];

  direct_mapped_icache_fill_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic icf_pkg::out_t cache_step(icf_pkg::in_t item);
    icf_pkg::out_t                  o;
    logic [icf_pkg::TAG_W-1:0]      tag;
    logic [icf_pkg::SET_BITS-1:0]   set_idx;
    logic [icf_pkg::WORD_IDX_W-1:0] widx;
    tag = item.address[icf_pkg::ADDR_W-1 -: icf_pkg::TAG_W];
    set_idx = item.address[icf_pkg::LINE_LOG2 +: icf_pkg::SET_BITS];
    widx = item.address[2 +: icf_pkg::WORD_IDX_W];
    o = '0;
    case (cache_mode)
      icf_pkg::M_READY: begin
        if (tag_ok[set_idx] && tag_mem[set_idx] == tag) begin
          o.read_data = line_mem[widx];
          o.read_valid = 1'b1;
        end else begin
          words_left = icf_pkg::WL_W'(icf_pkg::WORDS_PER_LINE);
          fill_ptr = {item.address[icf_pkg::ADDR_W-1:icf_pkg::LINE_LOG2],
                      icf_pkg::LINE_LOG2'(0)};
          miss_tag = tag;
          miss_set = set_idx;
          miss_widx = widx;
          cache_mode = icf_pkg::M_WANT;
        end
      end
      icf_pkg::M_WANT: begin
        wait_left = mem_latency;
        cache_mode = icf_pkg::M_FILL;
      end
      icf_pkg::M_FILL: begin
        if (wait_left == '0) begin
          // a fill with nothing left just holds
          if (words_left != '0) begin
            line_mem[fill_ptr[2 +: icf_pkg::WORD_IDX_W]] = item.mem_word;
            words_left = words_left - icf_pkg::WL_W'(1);
            fill_ptr = fill_ptr + icf_pkg::ADDR_W'(icf_pkg::WORD_BYTES);
            if (words_left == '0) cache_mode = icf_pkg::M_UPDATE;
          end
        end else begin
          wait_left = wait_left - icf_pkg::LAT_W'(1);
        end
      end
      default: begin
        tag_mem[miss_set] = miss_tag;
        tag_ok[miss_set] = 1'b1;
        o.read_data = line_mem[miss_widx];
        o.read_valid = 1'b1;
        cache_mode = icf_pkg::M_READY;
      end
    endcase
    o.ready_res = (cache_mode == icf_pkg::M_READY);
    o.fill_addr = fill_ptr;
    return o;
  endfunction

  function automatic icf_pkg::out_t mk_out(bit rdy, logic [icf_pkg::DATA_W-1:0] d, bit v,
                                           logic [icf_pkg::ADDR_W-1:0] f);
    icf_pkg::out_t o;
    o.ready_res = rdy;
    o.read_data = d;
    o.read_valid = v;
    o.fill_addr = f;
    return o;
  endfunction

  function automatic void flag_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    icf_pkg::out_t exp_w;
    if (!rst && done === 1'b1) begin
      if (expected_words.size() == 0) begin
        flag_mismatch("unexpected word", '0, result.fill_addr);
      end else begin
        exp_w = expected_words.pop_front();
        if (result.ready_res !== exp_w.ready_res)
          flag_mismatch("ready_res", 32'(exp_w.ready_res), 32'(result.ready_res));
        if (result.read_data !== exp_w.read_data)
          flag_mismatch("read_data", exp_w.read_data, result.read_data);
        if (result.read_valid !== exp_w.read_valid)
          flag_mismatch("read_valid", 32'(exp_w.read_valid), 32'(result.read_valid));
        if (result.fill_addr !== exp_w.fill_addr)
          flag_mismatch("fill_addr", exp_w.fill_addr, result.fill_addr);
      end
    end
  end

  task automatic send_word(icf_pkg::in_t item, bit typed, icf_pkg::out_t want);
    icf_pkg::out_t predicted;
    start <= 1'b1;
    req <= item;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = cache_step(item);
    expected_words.push_back(typed ? want : predicted);
  endtask

  task automatic maybe_idle(bit with_gaps);
    if (with_gaps && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_latency(logic [icf_pkg::LAT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mem_latency = v;
  endtask

  task automatic add_row(logic [31:0] a, logic [31:0] m, bit typed, icf_pkg::out_t want);
    stim_row_t r;
    r.req.address = a;
    r.req.mem_word = m;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endtask

  // mostly a small pool of conflicting lines so that hits and evictions are common
  function automatic logic [icf_pkg::ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 9) < 3) return $urandom;
    return {tag_pool[$urandom_range(0, 3)], set_pool[$urandom_range(0, 7)],
            icf_pkg::LINE_LOG2'($urandom)};
  endfunction

  initial begin
    logic [icf_pkg::DATA_W-1:0] fill_a [8];
    logic [icf_pkg::LAT_W-1:0]  lat_plan [5];
    icf_pkg::in_t               item;
    fill_a = '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0000, 32'hFFFF_FFFF,
               32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210};
    lat_plan = '{4'd15, 4'd6, icf_pkg::LAT_W'($urandom), 4'd0, icf_pkg::LAT_W'($urandom)};
    tag_pool = '{'0, '1, icf_pkg::TAG_W'($urandom), icf_pkg::TAG_W'($urandom)};
    set_pool[0] = '0;
    set_pool[1] = '1;
    for (int k = 2; k < 8; k++) set_pool[k] = icf_pkg::SET_BITS'($urandom);

    // top line of the address space, fill pointer wraps to zero on the last word
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, mk_out(1'b0, '0, 1'b0, 32'hFFFF_FFE0));
    // address is ignored while a line fill is pending
    add_row(32'h0000_0000, 32'h0000_0000, 1'b1, mk_out(1'b0, '0, 1'b0, 32'hFFFF_FFE0));
    for (int k = 0; k < 7; k++)
      add_row(k[0] ? 32'h0 : 32'hFFFF_FFFF, fill_a[k], 1'b0, '0);
    add_row(32'h0000_0000, fill_a[7], 1'b1, mk_out(1'b0, '0, 1'b0, 32'h0000_0000));
    add_row(32'h1234_5678, 32'h0, 1'b1, mk_out(1'b1, fill_a[7], 1'b1, 32'h0000_0000));
    add_row(32'hFFFF_FFE3, 32'hFFFF_FFFF, 1'b1,
            mk_out(1'b1, fill_a[0], 1'b1, 32'h0000_0000));
    // same set, other tag: evicts the top line
    add_row(32'h0000_3FE4, 32'h0, 1'b0, '0);
    for (int k = 0; k < 9; k++)
      add_row($urandom, $urandom, 1'b0, '0);
    add_row(32'h0000_0000, 32'h0, 1'b0, '0);
    add_row(32'hFFFF_FFFC, 32'h0, 1'b1, mk_out(1'b0, '0, 1'b0, 32'hFFFF_FFE0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // tag clearing pass runs after reset
    do @(posedge clk); while (busy !== 1'b0);

    write_latency('0);
    foreach (plan[i]) begin
      maybe_idle(1'b1);
      send_word(plan[i].req, plan[i].typed, plan[i].want);
    end
    drain();

    foreach (lat_plan[p]) begin
      write_latency(lat_plan[p]);
      for (int i = 0; i < 130; i++) begin
        maybe_idle(p != 4);
        item.address = pick_address();
        item.mem_word = $urandom;
        send_word(item, 1'b0, '0);
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
